// ===== sv/isolated_pixel_removal_assert.svh =====
// Assertion macros for the isolated pixel removal block.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ISOLATED_PIXEL_REMOVAL_ASSERT_SVH
`define ISOLATED_PIXEL_REMOVAL_ASSERT_SVH

`ifndef ASSERT_OFF
`define IPR_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define IPR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IPR_ASSERT_IMPLY(lbl, ante, cons)
`define IPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/ipr_pkg.sv =====
package ipr_pkg;

   localparam int PIX_W = 8;
   localparam int CSR_W = 11;

   localparam logic [PIX_W-1:0] PIXEL_ZERO = 8'h00;

   // request kind carried on tuser
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // configuration register indexes
   localparam logic CSR_FRAME_COLS = 1'b0;
   localparam logic CSR_FRAME_ROWS = 1'b1;

   // per-request flags computed at the read stage
   typedef struct packed {
      logic emit;
      logic last;
      logic left_ok;
      logic right_ok;
      logic up_ok;
      logic down_ok;
      logic is_pixel;
      logic rd_ok;
   } ctl_type;

endpackage

// ===== sv/isolated_pixel_removal.sv =====
// Isolated pixel removal, 3x3 neighborhood, 8-bit raster stream.
// Requests enter on req_* (tuser = 0: pixel, tuser = 1: drain tick); cleaned
// pixels leave on rsp_* with tlast on the final pixel of the frame. The frame
// size comes from csr_*: index 0 = columns, index 1 = rows, each clamped to
// 1..MAX_COLS / 1..MAX_ROWS; any write restarts the frame at row 0, col 0.
// One request per clock is accepted while req_tready is high. A pixel's
// result appears frame_cols + 1 requests after it, registered first in the
// line store read stage and then in the output register. After the last
// pixel of a frame, frame_cols + 1 drain ticks push out the pending tail;
// drain ticks at other times are dropped. The two line stores share one
// MAX_COLS x 16 memory, read and written back at the same column; a read of
// a column in the same clock as a write to that column is forwarded.
// Reset (synchronous) clears the position, the window and all valid flags;
// the memory keeps its contents and needs no clearing pass.
// When rsp_tready is low and the output register is full, requests keep
// flowing until one that produces a result reaches the window; req_tready
// then drops until the output register frees.
module isolated_pixel_removal #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ipr_pkg::PIX_W-1:0]   req_tdata,   // [7:0] pixel_in
   input  logic                        req_tuser,   // [0] opcode
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ipr_pkg::PIX_W-1:0]   rsp_tdata,   // [7:0] pixel_out
   output logic                        rsp_tlast,   // last_of_frame
   // configuration
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [ipr_pkg::CSR_W-1:0]   csr_wdata
);
   import ipr_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int ADDR_W = $clog2(MAX_COLS);
   localparam int RESET_COLS = (MAX_COLS < 1024) ? MAX_COLS : 1024;
   localparam int RESET_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

   // frame size and input position
   logic [COL_W-1:0] cols_ff;
   logic [ROW_W-1:0] rows_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // line store memory: [15:8] upper row, [7:0] middle row
   logic [2*PIX_W-1:0] mem [MAX_COLS];
   logic [2*PIX_W-1:0] mem_q_ff;
   logic               fwd_ff, fwd_in;
   logic [2*PIX_W-1:0] fwd_data_ff;

   // window stage
   logic               s1_valid_ff;
   ctl_type            s1_ctl_ff, ctl_in;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [PIX_W-1:0]   s1_px_ff;
   logic [PIX_W-1:0]   win0_ff [3];
   logic [PIX_W-1:0]   win1_ff [3];

   // output register
   logic               out_valid_ff;
   logic [PIX_W-1:0]   out_pixel_ff;
   logic               out_last_ff;

   logic               advance;
   logic               accept;
   logic               is_drain;
   logic               noop;
   logic               restart;
   logic [ROW_W-1:0]   r_cur;
   logic [COL_W-1:0]   c_cur;
   logic [COL_W:0]     c_p1;
   logic [ROW_W-1:0]   orow;
   logic [COL_W-1:0]   ocol;
   logic [COL_W:0]     ocol_p1;
   logic [ROW_W:0]     orow_p1;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we;
   logic [2*PIX_W-1:0] mem_data;
   logic [PIX_W-1:0]   top_px;
   logic [PIX_W-1:0]   mid_px;
   logic [PIX_W-1:0]   bot_px;
   logic [PIX_W-1:0]   nb;
   logic [PIX_W-1:0]   result_px;
   logic [COL_W-1:0]   csr_cols;
   logic [ROW_W-1:0]   csr_rows;

   // ---------------- request position ----------------
   assign is_drain = (req_tuser == OP_DRAIN);
   assign noop     = is_drain && (row_ff != rows_ff);
   assign restart  = !is_drain && (row_ff >= rows_ff);
   assign r_cur    = restart ? '0 : row_ff;
   assign c_cur    = restart ? '0 : col_ff;
   assign c_p1     = {1'b0, c_cur} + (COL_W+1)'(1);
   assign rd_addr  = c_cur[ADDR_W-1:0];

   always_comb begin
      if (!is_drain) begin
         if (c_p1 >= {1'b0, cols_ff}) begin
            col_in = '0;
            row_in = r_cur + ROW_W'(1);
         end else begin
            col_in = c_p1[COL_W-1:0];
            row_in = r_cur;
         end
      end else begin
         if (c_cur >= cols_ff) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = c_p1[COL_W-1:0];
            row_in = r_cur;
         end
      end
   end

   // position of the window center for this request
   always_comb begin
      if (c_cur != '0) begin
         orow = r_cur - ROW_W'(1);
         ocol = c_cur - COL_W'(1);
      end else begin
         orow = r_cur - ROW_W'(1) - ROW_W'(1);
         ocol = cols_ff - COL_W'(1);
      end
      ocol_p1 = {1'b0, ocol} + (COL_W+1)'(1);
      orow_p1 = {1'b0, orow} + (ROW_W+1)'(1);
      ctl_in.emit     = (r_cur != '0) && !((c_cur == '0) && (r_cur <= ROW_W'(1)));
      ctl_in.last     = (orow_p1 == {1'b0, rows_ff}) && (ocol_p1 == {1'b0, cols_ff});
      ctl_in.left_ok  = (ocol != '0);
      ctl_in.right_ok = (ocol_p1 < {1'b0, cols_ff});
      ctl_in.up_ok    = (orow != '0);
      ctl_in.down_ok  = (orow_p1 < {1'b0, rows_ff});
      ctl_in.is_pixel = !is_drain;
      ctl_in.rd_ok    = (c_cur < cols_ff);
   end

   // hold everything while a result would overwrite an untaken one
   assign advance    = !(s1_valid_ff && s1_ctl_ff.emit && out_valid_ff && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // ---------------- clamped configuration ----------------
   always_comb begin
      if (csr_wdata == '0) begin
         csr_cols = COL_W'(1);
         csr_rows = ROW_W'(1);
      end else begin
         csr_cols = (int'(csr_wdata) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(csr_wdata);
         csr_rows = (int'(csr_wdata) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COL_W'(RESET_COLS);
         rows_ff <= ROW_W'(RESET_ROWS);
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_COLS: cols_ff <= csr_cols;
            CSR_FRAME_ROWS: rows_ff <= csr_rows;
            default: ;
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept && !noop) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line store read, modify, write ----------------
   assign mem_data = fwd_ff ? fwd_data_ff : mem_q_ff;
   assign top_px   = s1_ctl_ff.rd_ok    ? mem_data[2*PIX_W-1:PIX_W] : PIXEL_ZERO;
   assign mid_px   = s1_ctl_ff.rd_ok    ? mem_data[PIX_W-1:0]       : PIXEL_ZERO;
   assign bot_px   = s1_ctl_ff.is_pixel ? s1_px_ff                  : PIXEL_ZERO;
   assign mem_we   = s1_valid_ff && s1_ctl_ff.is_pixel && advance;
   assign fwd_in   = mem_we && (rd_addr == s1_addr_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s1_addr_ff] <= {mem_data[PIX_W-1:0], s1_px_ff};
      end
      if (advance) begin
         mem_q_ff    <= mem[rd_addr];
         fwd_data_ff <= {mem_data[PIX_W-1:0], s1_px_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && !noop && !csr_we;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctl_ff  <= ctl_in;
         s1_addr_ff <= rd_addr;
         s1_px_ff   <= req_tdata;
      end
   end

   // ---------------- 3x3 window ----------------
   // left column win0, center column win1, right column from the store and the request pixel
   always_comb begin
      nb = PIXEL_ZERO;
      if (s1_ctl_ff.left_ok)  nb = nb | win0_ff[1];
      if (s1_ctl_ff.right_ok) nb = nb | mid_px;
      if (s1_ctl_ff.up_ok) begin
         nb = nb | win1_ff[0];
         if (s1_ctl_ff.left_ok)  nb = nb | win0_ff[0];
         if (s1_ctl_ff.right_ok) nb = nb | top_px;
      end
      if (s1_ctl_ff.down_ok) begin
         nb = nb | win1_ff[2];
         if (s1_ctl_ff.left_ok)  nb = nb | win0_ff[2];
         if (s1_ctl_ff.right_ok) nb = nb | bot_px;
      end
      result_px = (nb == PIXEL_ZERO) ? PIXEL_ZERO : win1_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            win0_ff[i] <= PIXEL_ZERO;
            win1_ff[i] <= PIXEL_ZERO;
         end
      end else if (advance && s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win0_ff[i] <= win1_ff[i];
         end
         win1_ff[0] <= top_px;
         win1_ff[1] <= mid_px;
         win1_ff[2] <= bot_px;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && s1_valid_ff && s1_ctl_ff.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && s1_ctl_ff.emit) begin
         out_pixel_ff <= result_px;
         out_last_ff  <= s1_ctl_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions ----------------
`include "isolated_pixel_removal_assert.svh"

   `IPR_ASSERT_IMPLY(a_row_bound, 1'b1, row_ff <= rows_ff)
   `IPR_ASSERT_IMPLY(a_col_bound, row_ff < rows_ff, col_ff < cols_ff)
   `IPR_ASSERT_IMPLY(a_write_in_frame, s1_valid_ff && s1_ctl_ff.is_pixel, s1_ctl_ff.rd_ok)
   `IPR_ASSERT_NEXT(a_stall_hold, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_addr_ff))

endmodule

// ===== tb/isolated_pixel_removal_tb.sv =====
module isolated_pixel_removal_tb;
   import ipr_pkg::*;

   localparam int FRAME_COLS_MAX = 1024;
   localparam int FRAME_ROWS_MAX = 1024;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } cleaned_px_type;

   class speckle_filter_sb;
      bit [PIX_W-1:0] upper_row [FRAME_COLS_MAX];
      bit [PIX_W-1:0] middle_row [FRAME_COLS_MAX];
      bit [PIX_W-1:0] win [3][3];
      int unsigned    in_row;
      int unsigned    in_col;
      int unsigned    cols_reg;
      int unsigned    rows_reg;
      cleaned_px_type pixels_due[$];
      int             mismatches;
      int             results_checked;

      function void clear_state();
         in_row = 0;
         in_col = 0;
         cols_reg = 1024;
         rows_reg = 1024;
         foreach (win[i, j]) win[i][j] = PIXEL_ZERO;
         pixels_due.delete();
      endfunction

      function int unsigned clamp_dim(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned eff_cols();
         return clamp_dim(cols_reg, FRAME_COLS_MAX);
      endfunction

      function int unsigned eff_rows();
         return clamp_dim(rows_reg, FRAME_ROWS_MAX);
      endfunction

      // any write restarts the frame; stores and window keep their contents
      function void write_reg(logic idx, logic [CSR_W-1:0] value);
         if (idx == CSR_FRAME_COLS) cols_reg = value;
         else rows_reg = value;
         in_row = 0;
         in_col = 0;
      endfunction

      function void note_request(logic op, logic [PIX_W-1:0] px);
         int unsigned      cols;
         int unsigned      rows;
         int unsigned      r;
         int unsigned      c;
         int unsigned      orow;
         int unsigned      ocol;
         logic [PIX_W-1:0] top;
         logic [PIX_W-1:0] mid;
         logic [PIX_W-1:0] nb;
         cleaned_px_type   due;
         cols = eff_cols();
         rows = eff_rows();
         if (op == OP_DRAIN) begin
            if (in_row != rows) return;
         end else if (in_row >= rows) begin
            in_row = 0;
            in_col = 0;
         end
         r = in_row;
         c = in_col;
         top = PIXEL_ZERO;
         mid = PIXEL_ZERO;
         if (c < cols) begin
            top = upper_row[c];
            mid = middle_row[c];
            if (op == OP_PIXEL) begin
               upper_row[c] = mid;
               middle_row[c] = px;
            end
         end
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = (op == OP_PIXEL) ? px : PIXEL_ZERO;

         if (op == OP_PIXEL) begin
            if (c + 1 >= cols) begin
               in_col = 0;
               in_row = r + 1;
            end else begin
               in_col = c + 1;
            end
         end else begin
            if (c >= cols) begin
               in_row = 0;
               in_col = 0;
            end else begin
               in_col = c + 1;
            end
         end

         if (r == 0) return;
         if (c == 0 && r < 2) return;
         if (c >= 1) begin
            orow = r - 1;
            ocol = c - 1;
         end else begin
            orow = r - 2;
            ocol = cols - 1;
         end

         // mask neighbors that fall outside the frame
         nb = PIXEL_ZERO;
         if (ocol > 0) nb |= win[1][0];
         if (ocol + 1 < cols) nb |= win[1][2];
         if (orow > 0) begin
            nb |= win[0][1];
            if (ocol > 0) nb |= win[0][0];
            if (ocol + 1 < cols) nb |= win[0][2];
         end
         if (orow + 1 < rows) begin
            nb |= win[2][1];
            if (ocol > 0) nb |= win[2][0];
            if (ocol + 1 < cols) nb |= win[2][2];
         end
         due.pixel = (nb == PIXEL_ZERO) ? PIXEL_ZERO : win[1][1];
         due.last = (orow + 1 == rows && ocol + 1 == cols);
         pixels_due.push_back(due);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_result(logic [PIX_W-1:0] pixel, logic last);
         cleaned_px_type due;
         results_checked++;
         if (pixels_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result pixel=%02h last=%0b", pixel, last));
            return;
         end
         due = pixels_due.pop_front();
         if (pixel !== due.pixel || last !== due.last)
            report_mismatch($sformatf("result %0d: pixel=%02h last=%0b, due pixel=%02h last=%0b",
                                      results_checked, pixel, last, due.pixel, due.last));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [PIX_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [PIX_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             csr_we;
   logic             csr_addr;
   logic [CSR_W-1:0] csr_wdata;

   speckle_filter_sb sb;
   int               req_gap_mode;
   int               rsp_gap_mode;
   int               requests_sent;
   int               frames_sent;

   isolated_pixel_removal #(
      .MAX_COLS(FRAME_COLS_MAX),
      .MAX_ROWS(FRAME_ROWS_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mode 0: never idle, 1: uniform 0..16, 2: occasional gap
   function automatic int draw_gap(int mode);
      unique case (mode)
         0: return 0;
         1: return $urandom_range(0, 16);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] draw_pixel(int density);
      if ($urandom_range(0, 99) >= density) return PIXEL_ZERO;
      unique case ($urandom_range(0, 3))
         0: return 8'hFF;
         1: return 8'h01;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge with tvalid still high
   task automatic send_request(logic op, logic [PIX_W-1:0] px);
      int gap;
      gap = draw_gap(req_gap_mode);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = px;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(op, px);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_drains(int count);
      repeat (count) send_request(OP_DRAIN, 8'($urandom));
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] value);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // hold until every due result is out, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.pixels_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin : result_sink
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = draw_gap(rsp_gap_mode);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1 || reset);
         sb.check_result(rsp_tdata, rsp_tlast);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int         cols_w;
      int         rows_w;
      int         cols_eff;
      int         rows_eff;
      int         n;
      int         stop_at;
      int         style;
      int         density;
      bit         force_write;
      bit         keep_cfg;
      logic [7:0] corner_frame [9];

      sb = new;
      sb.clear_state();
      req_gap_mode = 0;
      rsp_gap_mode = 0;
      req_tvalid = 1'b0;
      req_tdata = PIXEL_ZERO;
      req_tuser = OP_PIXEL;
      csr_we = 1'b0;
      csr_addr = CSR_FRAME_COLS;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // 3x3 frame with two isolated corners and an early drain that is dropped
      write_csr(CSR_FRAME_COLS, 11'd3);
      write_csr(CSR_FRAME_ROWS, 11'd3);
      send_request(OP_DRAIN, 8'hFF);
      corner_frame = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
      foreach (corner_frame[i]) send_request(OP_PIXEL, corner_frame[i]);
      send_drains(4);
      send_drains(1);

      // short drain, then a pixel that starts a fresh frame
      wait_idle();
      rsp_gap_mode = 1;
      write_csr(CSR_FRAME_COLS, 11'd2);
      write_csr(CSR_FRAME_ROWS, 11'd1);
      send_request(OP_PIXEL, 8'h01);
      send_request(OP_PIXEL, 8'h02);
      send_drains(1);
      send_request(OP_PIXEL, 8'h7F);

      // restart mid-frame; zero sizes clamp to a single pixel
      wait_idle();
      write_csr(CSR_FRAME_ROWS, 11'd0);
      write_csr(CSR_FRAME_COLS, 11'd0);
      send_request(OP_PIXEL, 8'hFF);
      send_drains(2);

      // oversized registers clamp to the full width; run past one line
      wait_idle();
      write_csr(CSR_FRAME_COLS, 11'h7FF);
      write_csr(CSR_FRAME_ROWS, 11'h7FF);
      req_gap_mode = 2;
      rsp_gap_mode = 2;
      repeat (FRAME_COLS_MAX + 60) send_request(OP_PIXEL, draw_pixel(8));

      force_write = 1'b1;
      keep_cfg = 1'b0;
      while (requests_sent < 1500) begin
         cols_w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
         rows_w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         if (force_write || (!keep_cfg && $urandom_range(0, 2) != 0)) begin
            wait_idle();
            if ($urandom_range(0, 1) == 1) begin
               write_csr(CSR_FRAME_COLS, 11'(cols_w));
               write_csr(CSR_FRAME_ROWS, 11'(rows_w));
            end else begin
               write_csr(CSR_FRAME_ROWS, 11'(rows_w));
               write_csr(CSR_FRAME_COLS, 11'(cols_w));
            end
         end
         force_write = 1'b0;
         keep_cfg = 1'b0;
         cols_eff = sb.eff_cols();
         rows_eff = sb.eff_rows();
         req_gap_mode = $urandom_range(0, 2);
         rsp_gap_mode = $urandom_range(0, 2);
         density = $urandom_range(3, 60);
         n = cols_eff * rows_eff;
         style = $urandom_range(0, 9);
         stop_at = (style == 0 && n > 1) ? $urandom_range(1, n - 1) : n;
         for (int i = 0; i < stop_at; i++) begin
            if ($urandom_range(0, 24) == 0) send_request(OP_DRAIN, 8'($urandom));
            send_request(OP_PIXEL, draw_pixel(density));
         end
         if (style == 0) begin
            // truncated frame: the next register write restarts it
            force_write = 1'b1;
         end else if (style == 1) begin
            // cut the drain short so the next frame's pixel drops the tail
            send_drains($urandom_range(0, cols_eff));
            keep_cfg = 1'b1;
         end else begin
            send_drains(cols_eff + 1);
            if ($urandom_range(0, 3) == 0) send_drains($urandom_range(1, 2));
         end
         frames_sent++;
      end

      req_tvalid = 1'b0;
      while (sb.pixels_due.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (sb.pixels_due.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pixels_due.size()));

      $display("Sent %0d requests over %0d random frames plus directed cases;",
               requests_sent, frames_sent);
      $display("checked %0d cleaned pixels, %0d mismatches.",
               sb.results_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
